### rtl/core/nicdf_pkg.sv
// ----------------------------------------------------------------------------
// nicdf_pkg: shared types and constants of the normal quantile pipeline
// Holds the Q.28 rational coefficients, the natural logarithm of two and the
// sideband tag that travels with each transaction through every stage.
// ----------------------------------------------------------------------------
package nicdf_pkg;

  // Fraction bits of t and of the rational approximation.
  localparam int unsigned TQ = 28;

  // ln(2) as an unsigned Q0.32 fraction.
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  // Numerator coefficients in Q.28.
  localparam logic [29:0] CF0 = 30'd675253953;
  localparam logic [27:0] CF1 = 28'd215514211;
  localparam logic [21:0] CF2 = 22'd2772401;

  // Denominator coefficients in Q.28.
  localparam logic [28:0] DF1 = 29'd384611100;
  localparam logic [25:0] DF2 = 26'd50806510;
  localparam logic [18:0] DF3 = 19'd351114;

  // Widths of the Horner intermediates; the values stay below these bounds.
  localparam int unsigned A1_W = 28;
  localparam int unsigned A2_W = 32;
  localparam int unsigned B1_W = 26;
  localparam int unsigned B2_W = 30;
  localparam int unsigned B3_W = 33;

  // Sideband that travels with each transaction.
  typedef struct packed {
    logic valid;
    logic neg;
    logic invalid;
  } tag_t;

endpackage

### rtl/core/nicdf_log.sv
// ----------------------------------------------------------------------------
// nicdf_log: tail selection, normalisation and u = -2 ln q
// Forms q = min(p, 1-p), normalises it to a Q1.30 mantissa, extracts log2 by
// one squaring per stage and scales the result by 2 ln 2.
// ----------------------------------------------------------------------------
module nicdf_log #(
  parameter int unsigned IN_FRAC_BITS = 32,
  parameter int unsigned U_W          = 40
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [IN_FRAC_BITS:0]   p_i,
  output nicdf_pkg::tag_t         tag_o,
  output logic [U_W-1:0]          u_o
);

  localparam int unsigned QW    = IN_FRAC_BITS;
  localparam int unsigned KW    = $clog2(IN_FRAC_BITS);
  localparam int unsigned PAD   = (QW < 31) ? 31 - QW : 0;
  localparam int unsigned NW    = QW + PAD;
  localparam int unsigned LHI_W = $clog2(IN_FRAC_BITS + 1);
  localparam int unsigned L_W   = LHI_W + 32;
  localparam int unsigned SQ_N  = 32;

  // Tail selection and leading one search.
  logic            inv_a, neg_a;
  logic [QW-1:0]   q_a;
  logic [KW-1:0]   lead_a;

  always_comb begin
    inv_a = (p_i == '0) || p_i[IN_FRAC_BITS];
    neg_a = !p_i[IN_FRAC_BITS-1];
    q_a   = neg_a ? p_i[QW-1:0] : (~p_i[QW-1:0] + QW'(1));
    lead_a = '0;
    for (int i = 0; i < QW; i++) begin
      if (q_a[i]) begin
        lead_a = KW'(i);
      end
    end
  end

  logic [QW-1:0]    qa_q;
  logic [KW-1:0]    ka_q;
  nicdf_pkg::tag_t  taga_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taga_q <= '0;
    end else begin
      taga_q <= '{valid: valid_i, neg: neg_a, invalid: inv_a};
    end
  end

  always_ff @(posedge clk_i) begin
    qa_q <= q_a;
    ka_q <= lead_a;
  end

  // Normalising shift: the leading one moves to bit 30 of the mantissa.
  logic [NW-1:0] ext_b, norm_b;

  always_comb begin
    ext_b  = NW'(qa_q) << PAD;
    norm_b = ext_b << (KW'(QW - 1) - ka_q);
  end

  logic [30:0]      sq_m_q    [0:SQ_N];
  logic [31:0]      sq_frac_q [0:SQ_N];
  logic [KW-1:0]    sq_k_q    [0:SQ_N];
  nicdf_pkg::tag_t  sq_tag_q  [0:SQ_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_tag_q[0] <= '0;
    end else begin
      sq_tag_q[0] <= taga_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_m_q[0]    <= norm_b[NW-1 -: 31];
    sq_frac_q[0] <= '0;
    sq_k_q[0]    <= ka_q;
  end

  // One squaring per stage gives one fraction bit of log2 of the mantissa.
  for (genvar j = 0; j < SQ_N; j++) begin : g_sq
    logic [61:0] prod;
    logic [31:0] v;

    always_comb begin
      prod = 62'(sq_m_q[j]) * 62'(sq_m_q[j]);
      v    = prod[61:30];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_tag_q[j+1] <= '0;
      end else begin
        sq_tag_q[j+1] <= sq_tag_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_m_q[j+1]    <= v[31] ? v[31:1] : v[30:0];
      sq_frac_q[j+1] <= {sq_frac_q[j][30:0], v[31]};
      sq_k_q[j+1]    <= sq_k_q[j];
    end
  end

  // L = -log2 q in Q.32.
  logic [L_W-1:0]   l_q;
  nicdf_pkg::tag_t  tagl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tagl_q <= '0;
    end else begin
      tagl_q <= sq_tag_q[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    l_q <= {LHI_W'(IN_FRAC_BITS) - LHI_W'(sq_k_q[SQ_N]), 32'd0} - L_W'(sq_frac_q[SQ_N]);
  end

  // Products of both halves of L with ln 2.
  logic [LHI_W+31:0] ph_q;
  logic [31:0]       pl_q;
  logic [63:0]       pl_full;
  nicdf_pkg::tag_t   tagp_q;

  assign pl_full = 64'(l_q[31:0]) * 64'(nicdf_pkg::LN2_Q32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tagp_q <= '0;
    end else begin
      tagp_q <= tagl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q <= (LHI_W + 32)'(l_q[L_W-1:32]) * (LHI_W + 32)'(nicdf_pkg::LN2_Q32);
    pl_q <= pl_full[63:32];
  end

  // u = 2 (hi * ln2 + lo * ln2).
  logic [U_W-1:0]   u_q;
  nicdf_pkg::tag_t  tagu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tagu_q <= '0;
    end else begin
      tagu_q <= tagp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= (U_W'(ph_q) + U_W'(pl_q)) << 1;
  end

  assign tag_o = tagu_q;
  assign u_o   = u_q;

endmodule

### rtl/core/nicdf_sqrt.sv
// ----------------------------------------------------------------------------
// nicdf_sqrt: pipelined integer square root
// Computes t = floor(sqrt(u * 2^24)) with one result bit per stage.
// ----------------------------------------------------------------------------
module nicdf_sqrt #(
  parameter int unsigned U_W    = 40,
  parameter int unsigned ROOT_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nicdf_pkg::tag_t   tag_i,
  input  logic [U_W-1:0]    u_i,
  output nicdf_pkg::tag_t   tag_o,
  output logic [ROOT_W-1:0] t_o
);

  localparam int unsigned RW = 2 * ROOT_W;

  logic [RW-1:0]    x_q   [0:ROOT_W];
  logic [RW-1:0]    r_q   [0:ROOT_W];
  nicdf_pkg::tag_t  tag_q [0:ROOT_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else begin
      tag_q[0] <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= RW'(u_i) << 24;
    r_q[0] <= '0;
  end

  // Restoring square root, one trial subtraction per stage.
  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * j);
    logic [RW-1:0] trial;
    logic          take;

    always_comb begin
      trial = r_q[j] + BIT;
      take  = (x_q[j] >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[j+1] <= '0;
      end else begin
        tag_q[j+1] <= tag_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (take) begin
        x_q[j+1] <= x_q[j] - trial;
        r_q[j+1] <= (r_q[j] >> 1) + BIT;
      end else begin
        x_q[j+1] <= x_q[j];
        r_q[j+1] <= r_q[j] >> 1;
      end
    end
  end

  assign tag_o = tag_q[ROOT_W];
  assign t_o   = r_q[ROOT_W][ROOT_W-1:0];

endmodule

### rtl/core/nicdf_poly.sv
// ----------------------------------------------------------------------------
// nicdf_poly: numerator and denominator polynomials in t
// Evaluates both polynomials by Horner's rule, with at most one multiply per polynomial in each stage.
// ----------------------------------------------------------------------------
module nicdf_poly #(
  parameter int unsigned T_W = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  nicdf_pkg::tag_t                  tag_i,
  input  logic [T_W-1:0]                   t_i,
  output nicdf_pkg::tag_t                  tag_o,
  output logic [T_W-1:0]                   t_o,
  output logic [nicdf_pkg::A2_W-1:0]       num_o,
  output logic [nicdf_pkg::B3_W-1:0]       den_o
);

  localparam int unsigned PA1_W = 22 + T_W;
  localparam int unsigned PB1_W = 19 + T_W;
  localparam int unsigned PA2_W = nicdf_pkg::A1_W + T_W;
  localparam int unsigned PB2_W = nicdf_pkg::B1_W + T_W;
  localparam int unsigned PB3_W = nicdf_pkg::B2_W + T_W;

  nicdf_pkg::tag_t  tag_q [0:3];
  logic [T_W-1:0]   t_q   [0:3];

  logic [PA1_W-1:0]               pa1_q;
  logic [PB1_W-1:0]               pb1_q;
  logic [PA2_W-1:0]               pa2_q;
  logic [PB2_W-1:0]               pb2_q;
  logic [nicdf_pkg::A2_W-1:0]     a2_q, a3_q;
  logic [PB3_W-1:0]               pb3_q;
  logic [nicdf_pkg::B3_W-1:0]     b3_q;

  logic [nicdf_pkg::A1_W-1:0]     a1;
  logic [nicdf_pkg::B1_W-1:0]     b1;
  logic [nicdf_pkg::B2_W-1:0]     b2;

  // Horner sums between the registered products.
  always_comb begin
    a1 = nicdf_pkg::A1_W'((pa1_q >> nicdf_pkg::TQ) + PA1_W'(nicdf_pkg::CF1));
    b1 = nicdf_pkg::B1_W'((pb1_q >> nicdf_pkg::TQ) + PB1_W'(nicdf_pkg::DF2));
    b2 = nicdf_pkg::B2_W'((pb2_q >> nicdf_pkg::TQ) + PB2_W'(nicdf_pkg::DF1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
      tag_q[1] <= '0;
      tag_q[2] <= '0;
      tag_q[3] <= '0;
    end else begin
      tag_q[0] <= tag_i;
      tag_q[1] <= tag_q[0];
      tag_q[2] <= tag_q[1];
      tag_q[3] <= tag_q[2];
    end
  end

  // Stage one: leading coefficients times t.
  always_ff @(posedge clk_i) begin
    t_q[0] <= t_i;
    pa1_q  <= PA1_W'(nicdf_pkg::CF2) * PA1_W'(t_i);
    pb1_q  <= PB1_W'(nicdf_pkg::DF3) * PB1_W'(t_i);
  end

  // Stage two: second Horner multiply.
  always_ff @(posedge clk_i) begin
    t_q[1] <= t_q[0];
    pa2_q  <= PA2_W'(a1) * PA2_W'(t_q[0]);
    pb2_q  <= PB2_W'(b1) * PB2_W'(t_q[0]);
  end

  // Stage three: numerator complete, last denominator multiply.
  always_ff @(posedge clk_i) begin
    t_q[2] <= t_q[1];
    a2_q   <= nicdf_pkg::A2_W'((pa2_q >> nicdf_pkg::TQ) + PA2_W'(nicdf_pkg::CF0));
    pb3_q  <= PB3_W'(b2) * PB3_W'(t_q[1]);
  end

  // Stage four: denominator complete.
  always_ff @(posedge clk_i) begin
    t_q[3] <= t_q[2];
    a3_q   <= a2_q;
    b3_q   <= nicdf_pkg::B3_W'((pb3_q >> nicdf_pkg::TQ) + (PB3_W'(1) << nicdf_pkg::TQ));
  end

  assign tag_o = tag_q[3];
  assign t_o   = t_q[3];
  assign num_o = a3_q;
  assign den_o = b3_q;

endmodule

### rtl/core/nicdf_div.sv
// ----------------------------------------------------------------------------
// nicdf_div: pipelined restoring divider
// Computes ratio = (num << 28) / den with one quotient bit per stage.
// ----------------------------------------------------------------------------
module nicdf_div #(
  parameter int unsigned T_W = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nicdf_pkg::tag_t               tag_i,
  input  logic [T_W-1:0]                t_i,
  input  logic [nicdf_pkg::A2_W-1:0]    num_i,
  input  logic [nicdf_pkg::B3_W-1:0]    den_i,
  output nicdf_pkg::tag_t               tag_o,
  output logic [T_W-1:0]                t_o,
  output logic [nicdf_pkg::A2_W-1:0]    ratio_o
);

  localparam int unsigned QW = nicdf_pkg::A2_W;
  localparam int unsigned RW = nicdf_pkg::A2_W + nicdf_pkg::TQ;
  localparam int unsigned DW = nicdf_pkg::B3_W + QW - 1;

  logic [RW-1:0]                 rem_q [0:QW];
  logic [nicdf_pkg::B3_W-1:0]    den_q [0:QW];
  logic [QW-1:0]                 quo_q [0:QW];
  logic [T_W-1:0]                t_q   [0:QW];
  nicdf_pkg::tag_t               tag_q [0:QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else begin
      tag_q[0] <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= RW'(num_i) << nicdf_pkg::TQ;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    t_q[0]   <= t_i;
  end

  // The quotient is known to fit QW bits, so each stage settles one bit.
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned SH = QW - 1 - j;
    logic [DW-1:0] dsh;
    logic          take;

    always_comb begin
      dsh  = DW'(den_q[j]) << SH;
      take = (DW'(rem_q[j]) >= dsh);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[j+1] <= '0;
      end else begin
        tag_q[j+1] <= tag_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[j+1] <= take ? RW'(DW'(rem_q[j]) - dsh) : rem_q[j];
      quo_q[j+1] <= {quo_q[j][QW-2:0], take};
      den_q[j+1] <= den_q[j];
      t_q[j+1]   <= t_q[j];
    end
  end

  assign tag_o   = tag_q[QW];
  assign t_o     = t_q[QW];
  assign ratio_o = quo_q[QW];

endmodule

### rtl/core/normal_inverse_cdf_rational.sv
// ----------------------------------------------------------------------------
// normal_inverse_cdf_rational: standard normal quantile by rational fit
// The path from start_i to done_o is long mainly because of the 32 log2
// squaring stages, the one-bit-per-stage square root and the
// one-bit-per-stage divider.
// Throughput: one transaction per cycle; busy_o is always low and the
// receiver cannot stall the results.
// Reset clears the valid bits of every stage; data registers are not reset.
// ----------------------------------------------------------------------------
module normal_inverse_cdf_rational #(
  parameter int unsigned IN_FRAC_BITS  = 32,
  parameter int unsigned OUT_FRAC_BITS = 27
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [IN_FRAC_BITS:0]   p_fraction_i,
  output logic                    done_o,
  output logic signed [31:0]      z_value_o,
  output logic                    invalid_input_o
);

  localparam int unsigned LHI_W  = $clog2(IN_FRAC_BITS + 1);
  localparam int unsigned U_W    = LHI_W + 34;
  localparam int unsigned ROOT_W = (U_W + 24 + 1) / 2;
  localparam int unsigned W_W    = ROOT_W + 1;
  localparam int unsigned MAG_W  = W_W;
  localparam int unsigned SH_L   = (OUT_FRAC_BITS >= nicdf_pkg::TQ) ?
                                   OUT_FRAC_BITS - nicdf_pkg::TQ : 0;
  localparam int unsigned SH_R   = (OUT_FRAC_BITS < nicdf_pkg::TQ) ?
                                   nicdf_pkg::TQ - OUT_FRAC_BITS : 0;
  localparam int unsigned SC_W   = MAG_W + SH_L + 1;
  localparam logic [SC_W-1:0] RND = (SH_R > 0) ?
                                    (SC_W'(1) << ((SH_R > 0) ? SH_R - 1 : 0)) : '0;
  localparam logic [SC_W-1:0] POS_MAX = SC_W'(32'h7FFFFFFF);
  localparam logic [SC_W-1:0] NEG_MAX = SC_W'(33'h080000000);

  // The pipeline never stalls.
  assign busy_o = 1'b0;

  // Input register.
  logic                   in_valid_q;
  logic [IN_FRAC_BITS:0]  p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_fraction_i;
  end

  // Logarithm, square root, polynomials and division.
  nicdf_pkg::tag_t             log_tag, sqrt_tag, poly_tag, div_tag;
  logic [U_W-1:0]              u_val;
  logic [ROOT_W-1:0]           t_sqrt, t_poly, t_div;
  logic [nicdf_pkg::A2_W-1:0]  num_val, ratio_val;
  logic [nicdf_pkg::B3_W-1:0]  den_val;

  nicdf_log #(
    .IN_FRAC_BITS (IN_FRAC_BITS),
    .U_W          (U_W)
  ) u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .p_i     (p_q),
    .tag_o   (log_tag),
    .u_o     (u_val)
  );

  nicdf_sqrt #(
    .U_W    (U_W),
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (log_tag),
    .u_i    (u_val),
    .tag_o  (sqrt_tag),
    .t_o    (t_sqrt)
  );

  nicdf_poly #(
    .T_W (ROOT_W)
  ) u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (sqrt_tag),
    .t_i    (t_sqrt),
    .tag_o  (poly_tag),
    .t_o    (t_poly),
    .num_o  (num_val),
    .den_o  (den_val)
  );

  nicdf_div #(
    .T_W (ROOT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (poly_tag),
    .t_i     (t_poly),
    .num_i   (num_val),
    .den_i   (den_val),
    .tag_o   (div_tag),
    .t_o     (t_div),
    .ratio_o (ratio_val)
  );

  // w = t - ratio, split into sign and magnitude.
  logic signed [W_W-1:0]  w_val;
  nicdf_pkg::tag_t        w_tag_q;
  logic [MAG_W-1:0]       mag_q;

  assign w_val = signed'(W_W'(t_div)) - signed'(W_W'(ratio_val));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_tag_q <= '0;
    end else begin
      w_tag_q <= '{valid:   div_tag.valid,
                   neg:     div_tag.neg ^ w_val[W_W-1],
                   invalid: div_tag.invalid};
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= w_val[W_W-1] ? MAG_W'(-w_val) : MAG_W'(w_val);
  end

  // Rescale to the output format, round when shifting right, saturate and apply the sign; an invalid input gives zero.
  logic [SC_W-1:0] scaled;
  logic [31:0]     z_d;

  always_comb begin
    if (SH_R > 0) begin
      scaled = (SC_W'(mag_q) + RND) >> SH_R;
    end else begin
      scaled = SC_W'(mag_q) << SH_L;
    end
    if (w_tag_q.invalid) begin
      z_d = '0;
    end else if (w_tag_q.neg) begin
      z_d = (scaled > NEG_MAX) ? 32'h80000000 : (32'd0 - scaled[31:0]);
    end else begin
      z_d = (scaled > POS_MAX) ? 32'h7FFFFFFF : scaled[31:0];
    end
  end

  logic         done_q;
  logic [31:0]  z_q;
  logic         inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= w_tag_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q   <= z_d;
    inv_q <= w_tag_q.invalid;
  end

  assign done_o          = done_q;
  assign z_value_o       = signed'(z_q);
  assign invalid_input_o = inv_q;

  // An accepted transaction always enters the pipeline.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> in_valid_q)
    else $error("accepted transaction did not enter the pipeline");

  // Nothing enters without a start.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |=> !in_valid_q)
    else $error("pipeline entry without start");

  // An invalid probability always yields a zero quantile.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && invalid_input_o) |-> (z_value_o == 32'sd0))
    else $error("invalid input gave a non-zero result");

endmodule
